[src/rau_pkg.sv]
// Shared opcodes, status codes and sequencer states of the rational arithmetic unit.
package rau_pkg;

  localparam int EXP_BITS = 6;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_MUL  = 3'd1;
  localparam logic [2:0] OP_POW  = 3'd2;
  localparam logic [2:0] OP_CMP  = 3'd3;
  localparam logic [2:0] OP_NORM = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERODEN = 2'd1;
  localparam logic [1:0] ST_OVF     = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_LOAD = 8'b0000_0100,
    S_GCD  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_PWR  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

endpackage

[src/rational_arithmetic_unit.sv]
// Rational ALU top level: sequencer around a shared multiplier, gcd and divider.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one beat with an opcode, two
//   fractions a and b and an exponent. Result channel (out_valid/out_ready)
//   returns one beat per input: reduced numerator and positive denominator,
//   compare flags and a status code.
//   in_ready is high only while the unit is idle; one item is in work at a
//   time. The time per item is data dependent: multiplies (add, multiply,
//   compare), binary gcd steps, two restoring divisions of 2*WORD_BITS-bit
//   operands, and for power a pre-reduction of a plus a numerator and a
//   denominator multiply per unit of exponent. The gcd loop and the
//   bit-serial divider take most of the time; faults found at the input
//   and compares skip them. Reset (rst_n low, synchronous) returns the
//   sequencer to idle and drops any pending result. When the receiver
//   stalls, the result beat is held in the output register and no new item
//   is taken until it is accepted.
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32,
  parameter int MAX_EXP   = 31
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_opcode,
  input  logic signed [WORD_BITS-1:0]        in_a_num,
  input  logic signed [WORD_BITS-1:0]        in_a_den,
  input  logic signed [WORD_BITS-1:0]        in_b_num,
  input  logic signed [WORD_BITS-1:0]        in_b_den,
  input  logic signed [rau_pkg::EXP_BITS-1:0] in_exponent,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [WORD_BITS-1:0]        out_res_num,
  output logic [WORD_BITS-2:0]               out_res_den,
  output logic                               out_is_less,
  output logic                               out_is_equal,
  output logic [1:0]                         out_status
);
  import rau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int DW = 2 * WORD_BITS;
  localparam int SW = $clog2(DW);
  localparam logic [DW-1:0] PMAX = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [DW-1:0] CAP  = PMAX + 1'b1;
  localparam logic [EXP_BITS:0] MAXK = (EXP_BITS+1)'(MAX_EXP);

  state_t state_r;

  logic [2:0]          op_r;
  logic [W-1:0]        pa_r, qa_r, pb_r, qb_r;
  logic                na_r, nb_r, neg_r, pre_r, inv_r;
  logic [EXP_BITS-1:0] k_r, i_r;
  logic [1:0]          mstep_r;
  logic                pstep_r;
  logic [DW-1:0]       x_r, y_r, nm_r, dm_r, u_r, v_r, g_r, dq_r, rem_r;
  logic [SW-1:0]       s_r, cnt_r;
  logic                sel_r;
  logic [W-1:0]        rn_r, rd_r, bn_r, bd_r;

  logic                out_valid_r, less_r, eq_r;
  logic [W-1:0]        res_num_r;
  logic [W-2:0]        res_den_r;
  logic [1:0]          status_r;

  // input magnitudes and signs
  logic [W-1:0]        pa_w, qa_w, pb_w, qb_w;
  logic                na_w, nb_w;
  logic [EXP_BITS-1:0] k_w;
  assign pa_w = in_a_num[W-1] ? (W'(0) - $unsigned(in_a_num)) : $unsigned(in_a_num);
  assign qa_w = in_a_den[W-1] ? (W'(0) - $unsigned(in_a_den)) : $unsigned(in_a_den);
  assign pb_w = in_b_num[W-1] ? (W'(0) - $unsigned(in_b_num)) : $unsigned(in_b_num);
  assign qb_w = in_b_den[W-1] ? (W'(0) - $unsigned(in_b_den)) : $unsigned(in_b_den);
  assign na_w = in_a_num[W-1] ^ in_a_den[W-1];
  assign nb_w = in_b_num[W-1] ^ in_b_den[W-1];
  assign k_w  = in_exponent[EXP_BITS-1] ? (EXP_BITS'(0) - $unsigned(in_exponent))
                                        : $unsigned(in_exponent);

  // shared multiplier
  logic [W-1:0]  mul_a, mul_b;
  logic [DW-1:0] prod;
  always_comb begin
    mul_a = qa_r;
    mul_b = qb_r;
    if (state_r == S_PWR) begin
      mul_a = pstep_r ? rd_r : rn_r;
      mul_b = pstep_r ? bd_r : bn_r;
    end else begin
      unique case (mstep_r)
        2'd0: begin mul_a = qa_r; mul_b = qb_r; end
        2'd1: begin mul_a = pa_r; mul_b = (op_r == OP_MUL) ? pb_r : qb_r; end
        2'd2: begin mul_a = pb_r; mul_b = qa_r; end
        default: begin mul_a = qa_r; mul_b = qb_r; end
      endcase
    end
  end
  assign prod = DW'(mul_a) * DW'(mul_b);

  // gcd step: one subtract yields |u - v|
  logic [DW:0]   gd;
  logic [DW-1:0] gabs;
  assign gd   = {1'b0, u_r} - {1'b0, v_r};
  assign gabs = gd[DW] ? (DW'(0) - gd[DW-1:0]) : gd[DW-1:0];

  // divider step
  logic [DW:0]   tr;
  logic          qbit;
  logic [DW:0]   tsub;
  logic [DW-1:0] quot;
  assign tr   = {rem_r, dq_r[DW-1]};
  assign tsub = tr - {1'b0, g_r};
  assign qbit = !tsub[DW];
  assign quot = {dq_r[DW-2:0], qbit};

  // add and compare on stored products
  logic [DW:0] xy_d;
  logic        na2, nb2;
  assign xy_d = {1'b0, x_r} - {1'b0, y_r};
  assign na2  = na_r && (x_r != '0);
  assign nb2  = nb_r && (y_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            pa_r    <= pa_w; qa_r <= qa_w; pb_r <= pb_w; qb_r <= qb_w;
            na_r    <= na_w; nb_r <= nb_w;
            inv_r   <= in_exponent[EXP_BITS-1];
            k_r     <= k_w;
            mstep_r <= 2'd0;
            res_num_r <= '0; res_den_r <= '0; less_r <= 1'b0; eq_r <= 1'b0;
            if (in_opcode > OP_NORM) begin
              status_r    <= ST_OK;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else if (qa_w == '0 || ((in_opcode == OP_ADD || in_opcode == OP_MUL ||
                         in_opcode == OP_CMP) && qb_w == '0)) begin
              status_r    <= ST_ZERODEN;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else if (in_opcode == OP_POW) begin
              if (k_w == '0) begin
                nm_r <= DW'(1); dm_r <= DW'(1); neg_r <= 1'b0;
                status_r <= ST_OK;
                pre_r    <= 1'b0;
                state_r  <= S_LOAD;
              end else if ({1'b0, k_w} > MAXK) begin
                status_r    <= ST_OVF;
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end else if (in_exponent[EXP_BITS-1] && pa_w == '0) begin
                status_r    <= ST_ZERODEN;
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end else begin
                nm_r <= DW'(pa_w); dm_r <= DW'(qa_w); neg_r <= 1'b0;
                status_r <= ST_OK;
                pre_r    <= 1'b1;
                state_r  <= S_LOAD;
              end
            end else if (in_opcode == OP_NORM) begin
              nm_r <= DW'(pa_w); dm_r <= DW'(qa_w); neg_r <= na_w;
              status_r <= ST_OK;
              pre_r    <= 1'b0;
              state_r  <= S_LOAD;
            end else begin
              status_r <= ST_OK;
              pre_r    <= 1'b0;
              state_r  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          mstep_r <= mstep_r + 2'd1;
          unique case (mstep_r)
            2'd0: dm_r <= prod;
            2'd1: x_r  <= prod;
            2'd2: y_r  <= prod;
            default: begin
              if (op_r == OP_MUL) begin
                nm_r <= x_r; neg_r <= na_r ^ nb_r; state_r <= S_LOAD;
              end else if (op_r == OP_ADD) begin
                state_r <= S_LOAD;
                if (na_r == nb_r) begin
                  nm_r <= x_r + y_r; neg_r <= na_r;
                end else if (!xy_d[DW]) begin
                  nm_r <= xy_d[DW-1:0]; neg_r <= na_r;
                end else begin
                  nm_r <= DW'(0) - xy_d[DW-1:0]; neg_r <= nb_r;
                end
              end else begin
                // compare with zero magnitudes treated as positive
                if (na2 != nb2) less_r <= na2;
                else if (x_r == y_r) eq_r <= 1'b1;
                else if (!na2) less_r <= xy_d[DW];
                else less_r <= !xy_d[DW];
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end
            end
          endcase
        end
        S_LOAD: begin
          s_r <= '0;
          if (nm_r == '0) begin
            dm_r <= DW'(1); neg_r <= 1'b0;
            u_r  <= '0; v_r <= DW'(1);
          end else begin
            u_r <= nm_r; v_r <= dm_r;
          end
          state_r <= S_GCD;
        end
        S_GCD: begin
          if (u_r == '0 || v_r == '0) begin
            g_r     <= (u_r | v_r) << s_r;
            dq_r    <= nm_r;
            rem_r   <= '0;
            cnt_r   <= '0;
            sel_r   <= 1'b0;
            state_r <= S_DIV;
          end else if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1; v_r <= v_r >> 1; s_r <= s_r + 1'b1;
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (!gd[DW]) begin
            u_r <= gabs;
          end else begin
            v_r <= gabs;
          end
        end
        S_DIV: begin
          if (cnt_r == SW'(DW-1)) begin
            cnt_r <= '0;
            rem_r <= '0;
            if (!sel_r) begin
              nm_r  <= quot;
              dq_r  <= dm_r;
              sel_r <= 1'b1;
            end else if (pre_r) begin
              // reduced a becomes the base; swap for a reciprocal
              bn_r    <= inv_r ? quot[W-1:0] : nm_r[W-1:0];
              bd_r    <= inv_r ? nm_r[W-1:0] : quot[W-1:0];
              rn_r    <= W'(1); rd_r <= W'(1);
              i_r     <= '0;
              pstep_r <= 1'b0;
              pre_r   <= 1'b0;
              state_r <= S_PWR;
            end else begin
              dm_r    <= quot;
              state_r <= S_FIN;
            end
          end else begin
            rem_r <= qbit ? tsub[DW-1:0] : tr[DW-1:0];
            dq_r  <= quot;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_PWR: begin
          if (i_r == k_r) begin
            nm_r <= DW'(rn_r); dm_r <= DW'(rd_r);
            neg_r   <= na_r && k_r[0];
            state_r <= S_LOAD;
          end else if (prod > CAP) begin
            status_r    <= ST_OVF;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            pstep_r <= !pstep_r;
            if (pstep_r) begin
              rd_r <= prod[W-1:0];
              i_r  <= i_r + 1'b1;
            end else begin
              rn_r <= prod[W-1:0];
            end
          end
        end
        S_FIN: begin
          if (dm_r > PMAX || nm_r > (neg_r ? CAP : PMAX)) begin
            status_r <= ST_OVF;
          end else begin
            res_num_r <= neg_r ? (W'(0) - nm_r[W-1:0]) : nm_r[W-1:0];
            res_den_r <= dm_r[W-2:0];
          end
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_res_num  = $signed(res_num_r);
  assign out_res_den  = res_den_r;
  assign out_is_less  = less_r;
  assign out_is_equal = eq_r;
  assign out_status   = status_r;

`ifndef SYNTH
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("input taken while result pending");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_res_num == '0 && out_res_den == '0))
    else $error("fault result carries data");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_equal) |-> !out_is_less) else $error("less and equal both set");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK && out_res_num != '0) |-> (out_res_den != '0))
    else $error("zero denominator on good result");
`endif

endmodule
